// ===== rtl/gct_pkg.sv =====
// Package for the gamma curve block: shared widths and the fixed log table.
// No dependencies; used by gct_div and gamma_curve_taylor.
package gct_pkg;

   localparam int DIVIDEND_W = 35;
   localparam int DIVISOR_W  = 7;
   localparam int CNT_W      = 6;

   // Series bookkeeping
   localparam logic [31:0] SUM_INIT  = 32'd65536;
   localparam logic [6:0]  MAX_TERMS = 7'd64;
   localparam logic [7:0]  GAMMA_RST = 8'd183;
   localparam logic [7:0]  LEVEL_MAX = 8'd255;

   // Divider handshake
   typedef struct packed {
      logic start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   // Magnitude of ln(x/256)*256 (the log itself is <= 0 for every entry).
   // Entries 29 and 45 keep their irregular values; entry 0 is never read.
   localparam logic [10:0] LN_MAG [256] = '{
      11'd0, 11'd1420, 11'd1242, 11'd1138, 11'd1065, 11'd1007, 11'd961, 11'd921,
      11'd887, 11'd857, 11'd830, 11'd806, 11'd783, 11'd762, 11'd744, 11'd726,
      11'd710, 11'd694, 11'd679, 11'd666, 11'd652, 11'd640, 11'd628, 11'd617,
      11'd606, 11'd596, 11'd586, 11'd576, 11'd567, 11'd577, 11'd549, 11'd541,
      11'd532, 11'd525, 11'd517, 11'd509, 11'd502, 11'd495, 11'd488, 11'd482,
      11'd475, 11'd469, 11'd463, 11'd457, 11'd451, 11'd455, 11'd439, 11'd434,
      11'd429, 11'd423, 11'd418, 11'd413, 11'd408, 11'd403, 11'd398, 11'd394,
      11'd389, 11'd385, 11'd380, 11'd376, 11'd371, 11'd367, 11'd363, 11'd359,
      11'd355, 11'd351, 11'd347, 11'd343, 11'd339, 11'd336, 11'd332, 11'd328,
      11'd325, 11'd321, 11'd318, 11'd314, 11'd311, 11'd308, 11'd304, 11'd301,
      11'd298, 11'd295, 11'd291, 11'd288, 11'd285, 11'd282, 11'd279, 11'd276,
      11'd273, 11'd271, 11'd268, 11'd265, 11'd262, 11'd259, 11'd257, 11'd254,
      11'd251, 11'd248, 11'd246, 11'd243, 11'd241, 11'd238, 11'd236, 11'd233,
      11'd231, 11'd228, 11'd226, 11'd223, 11'd221, 11'd219, 11'd216, 11'd214,
      11'd212, 11'd209, 11'd207, 11'd205, 11'd203, 11'd200, 11'd198, 11'd196,
      11'd194, 11'd192, 11'd190, 11'd188, 11'd186, 11'd184, 11'd182, 11'd180,
      11'd178, 11'd176, 11'd174, 11'd172, 11'd170, 11'd168, 11'd166, 11'd164,
      11'd162, 11'd160, 11'd158, 11'd156, 11'd155, 11'd153, 11'd151, 11'd149,
      11'd147, 11'd146, 11'd144, 11'd142, 11'd140, 11'd139, 11'd137, 11'd135,
      11'd134, 11'd132, 11'd130, 11'd128, 11'd127, 11'd125, 11'd124, 11'd122,
      11'd120, 11'd119, 11'd117, 11'd116, 11'd114, 11'd112, 11'd111, 11'd109,
      11'd108, 11'd106, 11'd105, 11'd103, 11'd102, 11'd100, 11'd99, 11'd97,
      11'd96, 11'd95, 11'd93, 11'd92, 11'd90, 11'd89, 11'd87, 11'd86,
      11'd85, 11'd83, 11'd82, 11'd80, 11'd79, 11'd78, 11'd76, 11'd75,
      11'd74, 11'd72, 11'd71, 11'd70, 11'd68, 11'd67, 11'd66, 11'd65,
      11'd63, 11'd62, 11'd61, 11'd59, 11'd58, 11'd57, 11'd56, 11'd54,
      11'd53, 11'd52, 11'd51, 11'd50, 11'd48, 11'd47, 11'd46, 11'd45,
      11'd44, 11'd42, 11'd41, 11'd40, 11'd39, 11'd38, 11'd37, 11'd35,
      11'd34, 11'd33, 11'd32, 11'd31, 11'd30, 11'd29, 11'd27, 11'd26,
      11'd25, 11'd24, 11'd23, 11'd22, 11'd21, 11'd20, 11'd19, 11'd18,
      11'd17, 11'd16, 11'd14, 11'd13, 11'd12, 11'd11, 11'd10, 11'd9,
      11'd8, 11'd7, 11'd6, 11'd5, 11'd4, 11'd3, 11'd2, 11'd1
   };

endpackage

// ===== rtl/gamma_curve_taylor.sv =====
// Top level: 8-bit gamma correction by an exp() Taylor series.
// Depends on gct_pkg (log table, widths) and gct_div (term divider).
//
//  channel | ports                                    | direction
//  req     | req_valid, req_stall, req_level_in       | in (stall out)
//  rsp     | rsp_valid, rsp_stall, rsp_level_out      | out (stall in)
//  csr     | csr_we, csr_gamma_setting                | in, write only
//
// One item at a time. Levels 0 and 255 go straight to the output. Other
// levels sum T nonzero series terms; each term is a loop, a multiply and a
// start state plus a wait on the 35-step bit-serial divide by n.
// req_stall is high from acceptance until the result transfers.
// Synchronous active-high reset; gamma resets to 183.
module gamma_curve_taylor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_level_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_level_out,
   input  logic       csr_we,
   input  logic [7:0] csr_gamma_setting
);
   import gct_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_LOOP, S_MUL, S_DIVS, S_DIVW, S_FIN, S_OUT
   } state_type;

   state_type    state_ff, state_in;
   logic [7:0]   gamma_ff;
   logic [7:0]   x_ff, x_in;
   logic [18:0]  p_ff, p_in;
   logic [31:0]  term_ff, term_in;
   logic [31:0]  sum_ff, sum_in;
   logic [6:0]   n_ff, n_in;
   logic [42:0]  prod_ff, prod_in;
   logic [7:0]   out_ff, out_in;
   logic [8:0]   gm_mag;
   logic [24:0]  scaled;
   div_req_type  dreq;
   div_rsp_type  drsp;

   gct_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // divider request
   always_comb begin
      dreq.start    = state_ff == S_DIVS;
      dreq.dividend = prod_ff[42:8];
      dreq.divisor  = n_ff;
   end

   // (256 - g) and final scaling
   always_comb begin
      gm_mag = 9'd256 - {1'b0, gamma_ff};
      scaled = sum_ff[24:8] * x_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      p_in     = p_ff;
      term_in  = term_ff;
      sum_in   = sum_ff;
      n_in     = n_ff;
      prod_in  = prod_ff;
      out_in   = out_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in = req_level_in;
               if (req_level_in == '0 || req_level_in == LEVEL_MAX) begin
                  out_in   = req_level_in;
                  state_in = S_OUT;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            p_in     = 19'(LN_MAG[x_ff] * gm_mag);
            state_in = S_LOOP;
         end
         S_LOOP: begin
            if (n_ff == 7'd1 && sum_ff == SUM_INIT && term_ff == '0) begin
               term_in = {13'd0, p_ff};
            end
            state_in = S_MUL;
            if (term_ff == '0 && !(n_ff == 7'd1 && sum_ff == SUM_INIT)) begin
               state_in = S_FIN;
            end else if (n_ff >= MAX_TERMS) begin
               state_in = S_FIN;
            end
            if (state_in == S_MUL) begin
               sum_in = sum_ff + term_in;
               n_in   = n_ff + 1'b1;
            end
         end
         S_MUL: begin
            prod_in  = term_ff[31:8] * p_ff;
            state_in = S_DIVS;
         end
         S_DIVS: state_in = S_DIVW;
         S_DIVW: begin
            if (drsp.done) begin
               term_in  = drsp.quotient[31:0];
               state_in = S_LOOP;
            end
         end
         S_FIN: begin
            out_in   = (scaled[24:8] > 17'd255) ? LEVEL_MAX : scaled[15:8];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // fresh item: seed the series
      if (state_ff == S_IDLE) begin
         sum_in  = SUM_INIT;
         n_in    = 7'd1;
         term_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gamma_ff <= GAMMA_RST;
      end else begin
         state_ff <= state_in;
         if (csr_we) gamma_ff <= csr_gamma_setting;
      end
      x_ff    <= x_in;
      p_ff    <= p_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      n_ff    <= n_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   assign req_stall     = state_ff != S_IDLE;
   assign rsp_valid     = state_ff == S_OUT;
   assign rsp_level_out = out_ff;

   // one item in flight: no input transfer while a result is pending
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   // divisor is a real term index during a divide
   a_div_n: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIVW |-> n_ff >= 7'd2 && n_ff <= MAX_TERMS)
      else $error("term index out of range");
   // result leaves only after a transfer
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_level_out))
      else $error("stalled result lost");

endmodule

// ===== rtl/gct_div.sv =====
// Restoring divider, one quotient bit per cycle (unsigned).
// Depends on gct_pkg for widths and the request/response structs.
module gct_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gct_pkg::div_req_type req,
   output gct_pkg::div_rsp_type rsp
);
   import gct_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // one shift/subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W - 1);
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   // remainder stays below the divisor
   a_rem_lt_div: assert property (@(posedge clock) disable iff (reset)
      busy_ff && dvs_ff != '0 |-> rem_ff < dvs_ff)
      else $error("divider remainder out of range");
   // done follows the last step
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");
   // busy and done are never high together
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff)
      else $error("divider busy and done together");

endmodule
